### sv/ptpq_pkg.sv
// Shared types and codes for the preemptive timed priority queue.
package ptpq_pkg;

    typedef enum logic [1:0] {
        ACT_SUBMIT  = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_ACK     = 3'd0,
        ST_INVALID = 3'd1,
        ST_DUP     = 3'd2,
        ST_FULL    = 3'd3,
        ST_DONE    = 3'd4
    } t_status;

    localparam logic [2:0] KIND_CANCEL = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_CUSTOM = 3'd4;

    localparam logic [2:0] REG_FEEDBACK = 3'd0;
    localparam logic [2:0] REG_EMPHASIS = 3'd1;
    localparam logic [2:0] REG_MAX_AMB  = 3'd2;
    localparam logic [2:0] REG_MAX_SEC  = 3'd3;
    localparam logic [2:0] REG_MAX_PRI  = 3'd4;
    localparam logic [2:0] REG_MAX_CRIT = 3'd5;

    localparam logic [15:0] MAX_RESET = 16'd500;
    localparam int          MAX_DONE  = 32;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] seq;
        logic [1:0]  pri;
        logic [15:0] dur;
        logic [15:0] el;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SUB,
        S_ADV,
        S_PICK,
        S_RES,
        S_EMIT_REQ,
        S_EMIT_PUT
    } t_state;

endpackage

### sv/preemptive_timed_priority_queue.sv
// Top level: cue scheduler with active slot, queue memory and completion buffer.
//
//  channel | signals                               | beat when
//  in      | i_in_valid / o_in_stall, i_* fields   | valid & !stall
//  out     | o_out_valid / i_out_stall, o_* fields | valid & !stall
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data     | we
//
// Submit: a tag and free-slot scan, one queue memory read per entry, then the
// result. Advance: advance steps, with a scan and pick after each completed cue
// that starts a queued one, then the result beats. One item at a time; o_in_stall
// is high while busy. Reset is synchronous; the queue memory needs no clearing pass.
module preemptive_timed_priority_queue #(
    parameter int QUEUE_DEPTH = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_request_tag,
    input  logic        i_request_ok,
    input  logic [2:0]  i_signal_kind,
    input  logic [1:0]  i_priority_tier,
    input  logic [15:0] i_custom_duration_ms,
    input  logic [15:0] i_delta_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_assigned_sequence,
    output logic        o_cue_done,
    output logic [31:0] o_done_tag,
    output logic [31:0] o_done_sequence,
    output logic        o_active_present,
    output logic [31:0] o_active_tag_out,
    output logic [4:0]  o_waiting_count,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ptpq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = $clog2(MAX_DONE);

    t_state r_state, n_state;

    logic [15:0] r_fb, r_emph;
    logic [15:0] r_max [4];

    t_entry         r_queue [QUEUE_DEPTH];
    t_entry         r_rdata;
    logic [63:0]    r_done_mem [MAX_DONE];
    logic [63:0]    r_done_rd;

    logic [QUEUE_DEPTH-1:0] r_valid;
    t_entry      r_act;
    logic        r_act_valid;
    logic [CW-1:0] r_qcount;
    logic [31:0] r_seqcnt;

    logic [31:0] r_req_tag;
    logic [1:0]  r_req_pri;
    logic [15:0] r_req_dur;
    logic [15:0] r_delta;

    logic [CW-1:0] r_sidx;
    logic [IW-1:0] r_pidx;
    logic        r_pv;
    logic        r_scan_adv;
    logic        r_dup;
    logic        r_free_found;
    logic [IW-1:0] r_free_idx;
    logic        r_best_found;
    logic [IW-1:0] r_best_idx;
    t_entry      r_best;

    logic [DW:0]   r_nd;
    logic [DW-1:0] r_k;
    t_status     r_res_status;
    logic [31:0] r_res_seq;

    logic        r_ov;
    logic [2:0]  r_o_status;
    logic [31:0] r_o_seq;
    logic        r_o_done;
    logic [31:0] r_o_dtag, r_o_dseq;
    logic        r_o_last;
    logic        r_o_apres;
    logic [31:0] r_o_atag;
    logic [4:0]  r_o_wcnt;

    logic        in_acc, out_free, out_load, scan_end, rd_en;
    logic [15:0] dur_new, base, rem;
    logic        req_bad, sub_dup, sub_full, sub_ok, preempt, adv_run, adv_fin;
    logic        cand_better;
    logic        w_we;
    t_entry      w_new, w_data;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ov || !i_out_stall;
    assign out_load = ((r_state == S_RES) || (r_state == S_EMIT_PUT)) && out_free;
    assign scan_end = (r_sidx == CW'(QUEUE_DEPTH)) && !r_pv;
    assign rd_en    = (r_state == S_SCAN) && (r_sidx != CW'(QUEUE_DEPTH));
    assign req_bad  = !i_request_ok || (i_signal_kind > KIND_CUSTOM);

    always_comb begin
        if (i_signal_kind <= KIND_CANCEL) begin
            base = r_fb;
        end else if (i_signal_kind == KIND_ERROR) begin
            base = r_emph;
        end else begin
            base = i_custom_duration_ms;
        end
        dur_new = (base == 16'd0) ? 16'd1 : base;
        if (dur_new > r_max[i_priority_tier]) begin
            dur_new = r_max[i_priority_tier];
        end
        if (dur_new == 16'd0) begin
            dur_new = 16'd1;
        end
    end

    assign sub_dup  = r_dup || (r_act_valid && r_act.tag == r_req_tag);
    assign sub_full = r_qcount >= CW'(QUEUE_DEPTH);
    assign sub_ok   = !sub_dup && !sub_full;
    assign preempt  = r_act_valid && (r_req_pri > r_act.pri);
    assign w_new    = '{tag: r_req_tag, seq: r_seqcnt, pri: r_req_pri, dur: r_req_dur,
                        el: 16'd0};
    assign w_we     = (r_state == S_SUB) && sub_ok && r_act_valid;
    assign w_data   = preempt ? r_act : w_new;

    assign rem     = r_act.dur - r_act.el;
    assign adv_run = (r_delta != 16'd0) && r_act_valid && (r_nd < (DW+1)'(MAX_DONE));
    assign adv_fin = r_delta >= rem;

    assign cand_better = !r_best_found || (r_rdata.pri > r_best.pri) ||
                         ((r_rdata.pri == r_best.pri) && (r_rdata.seq < r_best.seq));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_queue[r_free_idx] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= r_queue[r_sidx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADV && adv_run && adv_fin) begin
            r_done_mem[r_nd[DW-1:0]] <= {r_act.tag, r_act.seq};
        end
        if (r_state == S_EMIT_REQ) begin
            r_done_rd <= r_done_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (t_action'(i_action))
                        ACT_SUBMIT:  n_state = req_bad ? S_RES : S_SCAN;
                        ACT_ADVANCE: n_state = S_ADV;
                        default:     n_state = S_RES;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = r_scan_adv ? S_PICK : S_SUB;
                end
            end
            S_SUB: n_state = S_RES;
            S_ADV: begin
                if (adv_run) begin
                    n_state = (adv_fin && r_qcount != '0) ? S_SCAN : S_ADV;
                end else begin
                    n_state = (r_nd == '0) ? S_RES : S_EMIT_REQ;
                end
            end
            S_PICK: n_state = S_ADV;
            S_RES: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_REQ: n_state = S_EMIT_PUT;
            S_EMIT_PUT: begin
                if (out_free) begin
                    n_state = ({1'b0, r_k} == r_nd - 1'b1) ? S_IDLE : S_EMIT_REQ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb        <= '0;
            r_emph      <= '0;
            r_max[0]    <= MAX_RESET;
            r_max[1]    <= MAX_RESET;
            r_max[2]    <= MAX_RESET;
            r_max[3]    <= MAX_RESET;
            r_valid     <= '0;
            r_act_valid <= 1'b0;
            r_qcount    <= '0;
            r_seqcnt    <= 32'd1;
            r_ov        <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                priority case (i_cfg_index)
                    REG_FEEDBACK: r_fb     <= i_cfg_data;
                    REG_EMPHASIS: r_emph   <= i_cfg_data;
                    REG_MAX_AMB:  r_max[0] <= i_cfg_data;
                    REG_MAX_SEC:  r_max[1] <= i_cfg_data;
                    REG_MAX_PRI:  r_max[2] <= i_cfg_data;
                    REG_MAX_CRIT: r_max[3] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_ov      <= 1'b1;
                r_o_apres <= r_act_valid;
                r_o_atag  <= r_act_valid ? r_act.tag : 32'd0;
                r_o_wcnt  <= 5'(r_qcount);
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_req_tag    <= i_request_tag;
                    r_req_pri    <= i_priority_tier;
                    r_req_dur    <= dur_new;
                    r_delta      <= i_delta_ms;
                    r_nd         <= '0;
                    r_k          <= '0;
                    r_res_seq    <= '0;
                    r_sidx       <= '0;
                    r_dup        <= 1'b0;
                    r_free_found <= 1'b0;
                    r_best_found <= 1'b0;
                    r_scan_adv   <= 1'b0;
                    r_res_status <= (t_action'(i_action) == ACT_SUBMIT && req_bad) ?
                                    ST_INVALID : ST_DONE;
                    if (in_acc) begin
                        priority case (t_action'(i_action))
                            ACT_CLEAR: begin
                                r_valid     <= '0;
                                r_act_valid <= 1'b0;
                                r_qcount    <= '0;
                                r_seqcnt    <= 32'd1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_pv <= rd_en;
                    if (rd_en) begin
                        r_sidx <= r_sidx + 1'b1;
                        r_pidx <= r_sidx[IW-1:0];
                    end
                    if (r_pv) begin
                        if (r_valid[r_pidx]) begin
                            if (r_rdata.tag == r_req_tag) begin
                                r_dup <= 1'b1;
                            end
                            if (cand_better) begin
                                r_best_found <= 1'b1;
                                r_best_idx   <= r_pidx;
                                r_best       <= r_rdata;
                            end
                        end else if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pidx;
                        end
                    end
                end
                S_SUB: begin
                    if (sub_dup) begin
                        r_res_status <= ST_DUP;
                    end else if (sub_full) begin
                        r_res_status <= ST_FULL;
                    end else begin
                        r_res_status <= ST_ACK;
                        r_res_seq    <= r_seqcnt;
                        r_seqcnt     <= r_seqcnt + 32'd1;
                        if (!r_act_valid || preempt) begin
                            r_act       <= w_new;
                            r_act_valid <= 1'b1;
                        end
                        if (r_act_valid) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_qcount <= r_qcount + 1'b1;
                        end
                    end
                end
                S_ADV: begin
                    r_res_status <= ST_DONE;
                    r_sidx       <= '0;
                    r_pv         <= 1'b0;
                    r_best_found <= 1'b0;
                    r_scan_adv   <= 1'b1;
                    if (adv_run) begin
                        if (adv_fin) begin
                            r_delta     <= r_delta - rem;
                            r_act_valid <= 1'b0;
                            r_nd        <= r_nd + 1'b1;
                        end else begin
                            r_act.el <= r_act.el + r_delta;
                            r_delta  <= '0;
                        end
                    end
                end
                S_PICK: begin
                    r_act               <= r_best;
                    r_act_valid         <= 1'b1;
                    r_valid[r_best_idx] <= 1'b0;
                    r_qcount            <= r_qcount - 1'b1;
                end
                S_RES: begin
                    if (out_free) begin
                        r_o_status <= r_res_status;
                        r_o_seq    <= r_res_seq;
                        r_o_done   <= 1'b0;
                        r_o_dtag   <= '0;
                        r_o_dseq   <= '0;
                        r_o_last   <= 1'b1;
                    end
                end
                S_EMIT_REQ: ;
                S_EMIT_PUT: begin
                    if (out_free) begin
                        r_o_status <= ST_DONE;
                        r_o_seq    <= '0;
                        r_o_done   <= 1'b1;
                        r_o_dtag   <= r_done_rd[63:32];
                        r_o_dseq   <= r_done_rd[31:0];
                        r_o_last   <= ({1'b0, r_k} == r_nd - 1'b1);
                        r_k        <= r_k + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_ov;
    assign o_status            = r_o_status;
    assign o_assigned_sequence = r_o_seq;
    assign o_cue_done          = r_o_done;
    assign o_done_tag          = r_o_dtag;
    assign o_done_sequence     = r_o_dseq;
    assign o_active_present    = r_o_apres;
    assign o_active_tag_out    = r_o_atag;
    assign o_waiting_count     = r_o_wcnt;
    assign o_last              = r_o_last;

endmodule

### bench/preemptive_timed_priority_queue_test.sv
// Self-checking testbench for the preemptive timed priority cue scheduler.
`timescale 1ns / 1ps

import ptpq_pkg::*;

typedef struct {
    t_action     action;
    logic [31:0] tag;
    logic        ok;
    logic [2:0]  kind;
    logic [1:0]  pri;
    logic [15:0] custom;
    logic [15:0] delta;
} cue_item_t;

typedef struct {
    logic [2:0]  status;
    logic [31:0] aseq;
    logic        done;
    logic [31:0] dtag;
    logic [31:0] dseq;
    logic        apres;
    logic [31:0] atag;
    logic [4:0]  wcount;
    logic        last;
} cue_beat_t;

class cue_scoreboard;
    localparam int DEPTH = 31;

    logic [15:0] feedback_ms, emphasis_ms;
    logic [15:0] tier_ceiling[4];
    logic [31:0] s_tag[DEPTH + 1], s_seq[DEPTH + 1];
    logic [1:0]  s_pri[DEPTH + 1];
    logic [15:0] s_dur[DEPTH + 1], s_el[DEPTH + 1];
    bit          s_val[DEPTH + 1];
    logic [31:0] next_seq;
    int          waiting;
    cue_beat_t   expected_beats[$];
    int          fails;

    function new();
        feedback_ms = 0;
        emphasis_ms = 0;
        foreach (tier_ceiling[i]) tier_ceiling[i] = MAX_RESET;
        foreach (s_val[i]) s_val[i] = 0;
        next_seq = 1;
        waiting = 0;
        fails = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_FEEDBACK: feedback_ms = val;
            REG_EMPHASIS: emphasis_ms = val;
            REG_MAX_AMB:  tier_ceiling[0] = val;
            REG_MAX_SEC:  tier_ceiling[1] = val;
            REG_MAX_PRI:  tier_ceiling[2] = val;
            REG_MAX_CRIT: tier_ceiling[3] = val;
            default: ;
        endcase
    endfunction

    function void move_slot(int d, int s);
        s_tag[d] = s_tag[s]; s_seq[d] = s_seq[s]; s_pri[d] = s_pri[s];
        s_dur[d] = s_dur[s]; s_el[d] = s_el[s]; s_val[d] = s_val[s];
    endfunction

    function void enqueue(logic [31:0] tag, logic [31:0] seq, logic [1:0] pri,
                          logic [15:0] dur, logic [15:0] el);
        int p;
        p = 1;
        if (waiting >= DEPTH) return;
        while (p <= waiting) begin
            if (pri > s_pri[p] || (pri == s_pri[p] && seq < s_seq[p])) break;
            p++;
        end
        for (int i = waiting; i >= p; i--) move_slot(i + 1, i);
        s_tag[p] = tag; s_seq[p] = seq; s_pri[p] = pri;
        s_dur[p] = dur; s_el[p] = el; s_val[p] = 1;
        waiting++;
    endfunction

    function void promote_head();
        if (s_val[0] || waiting == 0) return;
        for (int i = 0; i < waiting; i++) move_slot(i, i + 1);
        s_val[waiting] = 0;
        waiting--;
    endfunction

    function void add_beat(t_status st, logic [31:0] aseq, logic done,
                           logic [31:0] dtag, logic [31:0] dseq, logic last);
        cue_beat_t b;
        b.status = st; b.aseq = aseq; b.done = done; b.dtag = dtag; b.dseq = dseq;
        b.apres = s_val[0];
        b.atag = s_val[0] ? s_tag[0] : 32'd0;
        b.wcount = waiting[4:0];
        b.last = last;
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    function t_status submit(cue_item_t it, output logic [31:0] seq);
        logic [15:0] dur;
        seq = 0;
        if (!it.ok || it.kind > KIND_CUSTOM) return ST_INVALID;
        if (s_val[0] && s_tag[0] == it.tag) return ST_DUP;
        for (int i = 1; i <= waiting; i++)
            if (s_tag[i] == it.tag) return ST_DUP;
        if (waiting >= DEPTH) return ST_FULL;
        if (it.kind <= KIND_CANCEL) dur = feedback_ms;
        else if (it.kind == KIND_ERROR) dur = emphasis_ms;
        else dur = it.custom;
        if (dur == 0) dur = 1;
        if (dur > tier_ceiling[it.pri]) dur = tier_ceiling[it.pri];
        if (dur == 0) dur = 1;
        seq = next_seq;
        next_seq = next_seq + 1;
        if (s_val[0] && it.pri > s_pri[0]) begin
            enqueue(s_tag[0], s_seq[0], s_pri[0], s_dur[0], s_el[0]);
            s_tag[0] = it.tag; s_seq[0] = seq; s_pri[0] = it.pri;
            s_dur[0] = dur; s_el[0] = 0; s_val[0] = 1;
        end else begin
            enqueue(it.tag, seq, it.pri, dur, 16'd0);
        end
        promote_head();
        return ST_ACK;
    endfunction

    function void note_item(cue_item_t it);
        logic [31:0] seq;
        t_status     st;
        logic [31:0] dtags[$], dseqs[$];
        logic [15:0] left, rem, used;
        case (it.action)
            ACT_SUBMIT: begin
                st = submit(it, seq);
                add_beat(st, seq, 0, 0, 0, 1);
            end
            ACT_CLEAR: begin
                foreach (s_val[i]) s_val[i] = 0;
                waiting = 0;
                next_seq = 1;
                add_beat(ST_DONE, 0, 0, 0, 0, 1);
            end
            ACT_ADVANCE: begin
                left = it.delta;
                while (left > 0 && s_val[0] && dtags.size() < MAX_DONE) begin
                    rem = s_dur[0] - s_el[0];
                    used = left < rem ? left : rem;
                    s_el[0] += used;
                    left -= used;
                    if (s_el[0] >= s_dur[0]) begin
                        dtags.insert(dtags.size(), s_tag[0]);
                        dseqs.insert(dseqs.size(), s_seq[0]);
                        s_val[0] = 0;
                        promote_head();
                    end
                end
                if (dtags.size() == 0) add_beat(ST_DONE, 0, 0, 0, 0, 1);
                foreach (dtags[k])
                    add_beat(ST_DONE, 0, 1, dtags[k], dseqs[k], k == dtags.size() - 1);
            end
            default: add_beat(ST_DONE, 0, 0, 0, 0, 1);
        endcase
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            fails++;
        end
    endfunction

    function void check_result(cue_beat_t r);
        cue_beat_t e;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual status %0d",
                     $time, r.status);
            fails++;
            return;
        end
        e = expected_beats.pop_front();
        compare("status", e.status, r.status);
        compare("assigned_sequence", e.aseq, r.aseq);
        compare("cue_done", e.done, r.done);
        compare("done_tag", e.dtag, r.dtag);
        compare("done_sequence", e.dseq, r.dseq);
        compare("active_present", e.apres, r.apres);
        compare("active_tag_out", e.atag, r.atag);
        compare("waiting_count", e.wcount, r.wcount);
        compare("last", e.last, r.last);
    endfunction
endclass

module preemptive_timed_priority_queue_test;
    localparam int STALL_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [1:0]  i_action = 0;
    logic [31:0] i_request_tag = 0;
    logic        i_request_ok = 0;
    logic [2:0]  i_signal_kind = 0;
    logic [1:0]  i_priority_tier = 0;
    logic [15:0] i_custom_duration_ms = 0;
    logic [15:0] i_delta_ms = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [2:0]  o_status;
    logic [31:0] o_assigned_sequence;
    logic        o_cue_done;
    logic [31:0] o_done_tag;
    logic [31:0] o_done_sequence;
    logic        o_active_present;
    logic [31:0] o_active_tag_out;
    logic [4:0]  o_waiting_count;
    logic        o_last;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;

    cue_scoreboard sb;
    bit            quiet = 0;
    int            stall_left = 0;
    int            idle_cycles = 0;
    int unsigned   fill_tag = 32'h8000_0000;

    preemptive_timed_priority_queue dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_out_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
        end
    end

    always @(posedge i_clk) begin
        cue_item_t it;
        cue_beat_t r;
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                it.action = t_action'(i_action); it.tag = i_request_tag;
                it.ok = i_request_ok; it.kind = i_signal_kind; it.pri = i_priority_tier;
                it.custom = i_custom_duration_ms; it.delta = i_delta_ms;
                sb.note_item(it);
            end
            if (o_out_valid && !i_out_stall) begin
                r.status = o_status; r.aseq = o_assigned_sequence; r.done = o_cue_done;
                r.dtag = o_done_tag; r.dseq = o_done_sequence; r.apres = o_active_present;
                r.atag = o_active_tag_out; r.wcount = o_waiting_count; r.last = o_last;
                sb.check_result(r);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(cue_item_t it);
        i_in_valid <= 1;
        i_action <= it.action; i_request_tag <= it.tag; i_request_ok <= it.ok;
        i_signal_kind <= it.kind; i_priority_tier <= it.pri;
        i_custom_duration_ms <= it.custom; i_delta_ms <= it.delta;
        do @(posedge i_clk); while (o_in_stall);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic cue(t_action a, logic [31:0] tag, logic ok, logic [2:0] kind,
                       logic [1:0] pri, logic [15:0] custom, logic [15:0] delta);
        cue_item_t it;
        it.action = a; it.tag = tag; it.ok = ok; it.kind = kind; it.pri = pri;
        it.custom = custom; it.delta = delta;
        send_item(it);
    endtask

    function automatic cue_item_t rand_item(bit fill);
        cue_item_t it;
        int r;
        it.tag = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 48);
        it.ok = $urandom_range(0, 15) != 0;
        it.kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) :
                                                 3'($urandom_range(0, 4));
        it.pri = 2'($urandom_range(0, 3));
        it.custom = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                  16'($urandom_range(0, 700));
        it.delta = ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                                                  16'($urandom_range(0, 400));
        r = $urandom_range(0, 99);
        if (fill || r < 58) it.action = ACT_SUBMIT;
        else if (r < 92) it.action = ACT_ADVANCE;
        else if (r < 96) it.action = ACT_CLEAR;
        else it.action = ACT_NONE;
        if (fill) begin
            it.ok = 1;
            it.kind = 3'($urandom_range(0, 4));
            it.tag = fill_tag;
            fill_tag++;
        end
        return it;
    endfunction

    task automatic run_random(int n, int fill_len);
        for (int i = 0; i < fill_len; i++) send_item(rand_item(1));
        for (int i = 0; i < n; i++) send_item(rand_item(0));
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_all(logic [15:0] fb, logic [15:0] em, logic [15:0] m0,
                           logic [15:0] m1, logic [15:0] m2, logic [15:0] m3);
        write_cfg(REG_FEEDBACK, fb); write_cfg(REG_EMPHASIS, em);
        write_cfg(REG_MAX_AMB, m0); write_cfg(REG_MAX_SEC, m1);
        write_cfg(REG_MAX_PRI, m2); write_cfg(REG_MAX_CRIT, m3);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset presets, every action and signal, edge tags
        cue(ACT_SUBMIT, 32'h0, 1, 3'd0, 2'd0, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'h0, 1, 3'd1, 2'd1, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'h5, 0, 3'd0, 2'd0, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'h6, 1, 3'd7, 2'd2, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'h7, 1, 3'd5, 2'd2, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'hFFFF_FFFF, 1, KIND_CANCEL, 2'd2, 16'hFFFF, 16'hFFFF);
        cue(ACT_SUBMIT, 32'h1, 1, 3'd1, 2'd1, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'h2, 1, KIND_ERROR, 2'd3, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'h3, 1, KIND_CUSTOM, 2'd3, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'h4, 1, KIND_CUSTOM, 2'd0, 16'hFFFF, 16'd0);
        cue(ACT_ADVANCE, 32'h0, 0, 3'd0, 2'd0, 16'd0, 16'd0);
        cue(ACT_ADVANCE, 32'h0, 0, 3'd0, 2'd0, 16'd0, 16'd1);
        cue(ACT_NONE, 32'hFFFF_FFFF, 1, 3'd7, 2'd3, 16'hFFFF, 16'hFFFF);
        cue(ACT_ADVANCE, 32'h0, 0, 3'd0, 2'd0, 16'd0, 16'hFFFF);
        cue(ACT_ADVANCE, 32'h0, 0, 3'd0, 2'd0, 16'd0, 16'd10);
        cue(ACT_SUBMIT, 32'h9, 1, KIND_CUSTOM, 2'd1, 16'd300, 16'd0);
        cue(ACT_CLEAR, 32'h0, 0, 3'd0, 2'd0, 16'd0, 16'd0);
        cue(ACT_SUBMIT, 32'h9, 1, KIND_CUSTOM, 2'd1, 16'd300, 16'd0);
        run_random(30, 0);
        drain();

        set_all(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'd300);
        cue(ACT_CLEAR, 32'h0, 0, 3'd0, 2'd0, 16'd0, 16'd0);
        run_random(12, 34);
        cue(ACT_ADVANCE, 32'h0, 0, 3'd0, 2'd0, 16'd0, 16'hFFFF);
        drain();

        set_all(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(35, 0);
        drain();

        set_all(16'd120, 16'd250, 16'd100, 16'd200, 16'd300, 16'd400);
        quiet = 1;
        run_random(30, 0);
        drain();

        if (sb.fails == 0 && sb.expected_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
